### rtl/imsm_pkg.sv
// imsm_pkg: types, constants and register indexes for the static imu mean init block
// no dependencies; imported by imsm_div and imu_static_mean_init_core
package imsm_pkg;

	// fixed field widths
	localparam int SAMPLE_BITS   = 16;
	localparam int MEAN_BITS     = 32;
	localparam int CNT_OUT_BITS  = 16;
	localparam int TARGET_BITS   = 16;
	localparam int CFG_ADDR_BITS = 1;
	localparam int CFG_DATA_BITS = 16;
	localparam int AXES          = 6;
	localparam int AXIS_BITS     = 3;

	// defaults for the top level parameters
	localparam int FRACTION_BITS_DEF = 16;
	localparam int COUNT_BITS_DEF    = 16;

	// reset values of the configuration registers
	localparam logic [TARGET_BITS-1:0] TARGET_RST = TARGET_BITS'(100);

	// register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_INIT_COUNT_TARGET = CFG_ADDR_BITS'(0);
	localparam logic [CFG_ADDR_BITS-1:0] REG_IMU_ENABLE        = CFG_ADDR_BITS'(1);

	// one imu sample beat
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic signed [SAMPLE_BITS-1:0] gyro_x;
		logic signed [SAMPLE_BITS-1:0] gyro_y;
		logic signed [SAMPLE_BITS-1:0] gyro_z;
		logic                          frame_end;
	} sample_t;

	// one result beat
	typedef struct packed {
		logic signed [MEAN_BITS-1:0]  mean_accel_x;
		logic signed [MEAN_BITS-1:0]  mean_accel_y;
		logic signed [MEAN_BITS-1:0]  mean_accel_z;
		logic signed [MEAN_BITS-1:0]  mean_gyro_x;
		logic signed [MEAN_BITS-1:0]  mean_gyro_y;
		logic signed [MEAN_BITS-1:0]  mean_gyro_z;
		logic [CNT_OUT_BITS-1:0]      sample_count;
		logic                         init_done;
	} result_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_ABS,
		ST_START,
		ST_DIV,
		ST_ACC,
		ST_SAT,
		ST_OUT
	} state_t;

endpackage

### rtl/imsm_div.sv
// imsm_div: bit-serial restoring divider, one quotient bit per cycle
// depends on imsm_pkg (imported for house consistency, no shared types used)
module imsm_div #(
	parameter int DIV_BITS = 33,
	parameter int DEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [DIV_BITS-1:0] quotient
);
	import imsm_pkg::*;

	localparam int CNT_W = $clog2(DIV_BITS);

	logic [DIV_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS:0]   trial_sub;
	logic                qbit;

	// one trial subtraction per cycle
	always_comb begin
		trial     = {rem_q, quo_q[DIV_BITS-1]};
		trial_sub = trial - {1'b0, den_q};
		qbit      = ~trial_sub[DEN_BITS];
	end

	// control: step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_BITS-2:0], qbit};
			rem_q <= qbit ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/imu_static_mean_init_core.sv
// imu_static_mean_init_core: running mean of six imu axes for static initialization
// depends on imsm_pkg and imsm_div
//
// Each accepted sample beat gives exactly one result beat with the six means (signed,
// FRACTION_BITS fraction bits), the current count and the done flag. While enabled and
// not done, the six axes are updated one after another through a single bit-serial
// divider that yields one quotient bit per cycle. The divider width D is max(16 +
// FRACTION_BITS, 32) + 1. A sample that arrives while disabled or after initialization
// is done skips the update and is passed straight to the output. The result sits in an
// output register, so a new sample can be taken while the last result waits.
module imu_static_mean_init_core #(
	parameter int FRACTION_BITS = imsm_pkg::FRACTION_BITS_DEF,
	parameter int COUNT_BITS    = imsm_pkg::COUNT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [imsm_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [imsm_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  imsm_pkg::sample_t                 sample,
	output logic                              result_valid,
	input  logic                              result_ready,
	output imsm_pkg::result_t                 result
);
	import imsm_pkg::*;

	localparam int SW   = SAMPLE_BITS + FRACTION_BITS;
	localparam int DW   = ((SW > MEAN_BITS) ? SW : MEAN_BITS) + 1;
	localparam int SUMW = DW + 1;
	localparam int CMPW = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;

	localparam logic signed [SUMW-1:0] MEAN_MAX = {{(SUMW - 31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SUMW-1:0] MEAN_MIN = {{(SUMW - 31){1'b1}}, {31{1'b0}}};
	localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};

	state_t state_q, state_d;

	// configuration
	logic [TARGET_BITS-1:0] target_q;
	logic                   enable_q;

	// state of the running mean
	logic signed [MEAN_BITS-1:0] means_q [AXES];
	logic [COUNT_BITS-1:0]       count_q;
	logic                        finished_q;

	// working registers
	sample_t                 in_q;
	logic [AXIS_BITS-1:0]    axis_q;
	logic signed [DW-1:0]    diff_s1;
	logic [DW-1:0]           mag_s2;
	logic                    neg_s2;
	logic signed [SUMW-1:0]  sum_s3;
	result_t                 result_q;
	logic                    result_valid_q;

	// control strobes
	logic accept;
	logic diff_ld;
	logic abs_ld;
	logic div_start;
	logic acc_ld;
	logic mean_wr;
	logic last_axis;
	logic out_ld;

	logic                    div_done;
	logic [DW-1:0]           div_quo;

	logic signed [SAMPLE_BITS-1:0] samples [AXES];
	logic signed [SAMPLE_BITS-1:0] sample_sel;
	logic signed [MEAN_BITS-1:0]   mean_sel;
	logic signed [DW-1:0]          scaled;
	logic signed [DW-1:0]          diff_d;
	logic signed [MEAN_BITS-1:0]   mean_sat;
	logic [COUNT_BITS-1:0]         count_inc;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			enable_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_INIT_COUNT_TARGET: target_q <= cfg_wdata[TARGET_BITS-1:0];
				REG_IMU_ENABLE:        enable_q <= cfg_wdata[0];
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					state_d = (enable_q && !finished_q) ? ST_DIFF : ST_OUT;
				end
			end
			ST_DIFF:  state_d = ST_ABS;
			ST_ABS:   state_d = ST_START;
			ST_START: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_ACC;
				end
			end
			ST_ACC:   state_d = ST_SAT;
			ST_SAT:   state_d = last_axis ? ST_OUT : ST_DIFF;
			ST_OUT: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		sample_ready = 1'b0;
		diff_ld      = 1'b0;
		abs_ld       = 1'b0;
		div_start    = 1'b0;
		acc_ld       = 1'b0;
		mean_wr      = 1'b0;
		out_ld       = 1'b0;
		unique case (state_q)
			ST_IDLE:  sample_ready = 1'b1;
			ST_DIFF:  diff_ld      = 1'b1;
			ST_ABS:   abs_ld       = 1'b1;
			ST_START: div_start    = 1'b1;
			ST_DIV:   acc_ld       = div_done;
			ST_ACC:   acc_ld       = 1'b0;
			ST_SAT:   mean_wr      = 1'b1;
			ST_OUT:   out_ld       = !result_valid_q || result_ready;
			default:  sample_ready = 1'b0;
		endcase
	end

	assign accept    = sample_valid && sample_ready;
	assign last_axis = (axis_q == AXIS_BITS'(AXES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// axis selection
	always_comb begin
		samples[0] = in_q.accel_x;
		samples[1] = in_q.accel_y;
		samples[2] = in_q.accel_z;
		samples[3] = in_q.gyro_x;
		samples[4] = in_q.gyro_y;
		samples[5] = in_q.gyro_z;
		sample_sel = samples[axis_q];
		mean_sel   = means_q[axis_q];
		scaled     = DW'(sample_sel) <<< FRACTION_BITS;
		diff_d     = scaled - DW'(mean_sel);
	end

	// saturate the updated mean to 32 bits
	always_comb begin
		if (sum_s3 > MEAN_MAX) begin
			mean_sat = MEAN_MAX[MEAN_BITS-1:0];
		end else if (sum_s3 < MEAN_MIN) begin
			mean_sat = MEAN_MIN[MEAN_BITS-1:0];
		end else begin
			mean_sat = sum_s3[MEAN_BITS-1:0];
		end
	end

	assign count_inc = (count_q != COUNT_MAX) ? count_q + COUNT_BITS'(1) : count_q;

	// sample beat and axis counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
		end else if (accept) begin
			axis_q <= '0;
		end else if (mean_wr && !last_axis) begin
			axis_q <= axis_q + AXIS_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= sample;
		end
	end

	// difference, magnitude and signed accumulate stages
	always_ff @(posedge clk) begin
		if (diff_ld) begin
			diff_s1 <= diff_d;
		end
		if (abs_ld) begin
			neg_s2 <= diff_s1[DW-1];
			mag_s2 <= diff_s1[DW-1] ? DW'(-diff_s1) : DW'(diff_s1);
		end
		if (acc_ld) begin
			sum_s3 <= neg_s2 ? SUMW'(mean_sel) - $signed({1'b0, div_quo})
			                 : SUMW'(mean_sel) + $signed({1'b0, div_quo});
		end
	end

	// mean, count and done state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXES; i++) begin
				means_q[i] <= '0;
			end
			count_q    <= COUNT_BITS'(1);
			finished_q <= 1'b0;
		end else if (mean_wr) begin
			means_q[axis_q] <= mean_sat;
			if (last_axis) begin
				count_q <= count_inc;
				if (in_q.frame_end && (CMPW'(count_inc) > CMPW'(target_q))) begin
					finished_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_ld) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			result_q.mean_accel_x <= means_q[0];
			result_q.mean_accel_y <= means_q[1];
			result_q.mean_accel_z <= means_q[2];
			result_q.mean_gyro_x  <= means_q[3];
			result_q.mean_gyro_y  <= means_q[4];
			result_q.mean_gyro_z  <= means_q[5];
			result_q.sample_count <= CNT_OUT_BITS'(count_q);
			result_q.init_done    <= finished_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// shared bit-serial divider
	imsm_div #(
		.DIV_BITS (DW),
		.DEN_BITS (COUNT_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_s2),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

endmodule
